@@ rtl/spfq_pkg.sv @@
// spfq_pkg: shared constants, codes and types of the strict priority queue
// used by spfq_store and strict_priority_fifo_queue; no dependencies
package spfq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int LEVELS      = 5;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // fixed field widths
  localparam int ID_W  = 16;
  localparam int URG_W = 3;
  localparam int OCC_W = 7;
  localparam int ST_W  = 2;

  // operation codes
  localparam logic FUNC_ENQ   = 1'b0;
  localparam logic FUNC_SERVE = 1'b1;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_ENQUEUED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // access to the entry store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ID_W-1:0]   wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

endpackage

@@ rtl/spfq_store.sv @@
// spfq_store: entry identifier memory, one write and one registered read per cycle
// depends on spfq_pkg
module spfq_store
  import spfq_pkg::*;
(
  input  logic             clk,
  input  store_req_t       req,
  output logic [ID_W-1:0]  rd_data
);

  logic [ID_W-1:0] mem [LEVELS*QUEUE_DEPTH];
  logic [ID_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/strict_priority_fifo_queue.sv @@
// strict_priority_fifo_queue: five-level strict priority queue, fifo order per level
// the result strobe comes in the cycle after the start transfer
// throughput: one item per cycle; a serve reads the store once, registered
// reset: pointers, counts and strobe cleared; the store keeps stale data
// the receiver cannot stall, so busy stays low
module strict_priority_fifo_queue
  import spfq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [ID_W-1:0]   in_entry_id,
  input  logic [URG_W-1:0]  in_urgency,
  output logic              out_strobe,
  output logic [ST_W-1:0]   out_status,
  output logic [ID_W-1:0]   out_served_id,
  output logic [URG_W-1:0]  out_served_urgency,
  output logic [OCC_W-1:0]  out_occupancy
);

  // per-level state
  logic [PTR_W-1:0] heads_r  [LEVELS];
  logic [PTR_W-1:0] heads_nxt[LEVELS];
  logic [PTR_W-1:0] tails_r  [LEVELS];
  logic [PTR_W-1:0] tails_nxt[LEVELS];
  logic [CNT_W-1:0] counts_r  [LEVELS];
  logic [CNT_W-1:0] counts_nxt[LEVELS];
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] total_nxt;

  // result registers
  logic             strobe_r;
  logic             strobe_nxt;
  status_t          status_r;
  status_t          status_nxt;
  logic             served_r;
  logic             served_nxt;
  logic [URG_W-1:0] urg_r;
  logic [URG_W-1:0] urg_nxt;
  logic [CNT_W-1:0] occ_r;

  logic             accept;
  logic [LVL_W-1:0] enq_idx;
  logic [LVL_W-1:0] srv_idx;
  logic             any_held;
  store_req_t       store_req;
  logic [ID_W-1:0]  store_rd_data;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // urgency clamp into a level index
  always_comb begin
    if (in_urgency == '0) begin
      enq_idx = '0;
    end else if ({1'b0, in_urgency} > (URG_W+1)'(LEVELS)) begin
      enq_idx = LVL_W'(LEVELS - 1);
    end else begin
      enq_idx = LVL_W'(in_urgency - URG_W'(1));
    end
  end

  // most urgent non-empty level
  always_comb begin
    logic found;
    found   = 1'b0;
    srv_idx = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (!found && counts_r[i] != '0) begin
        found   = 1'b1;
        srv_idx = LVL_W'(i);
      end
    end
    any_held = found;
  end

  // operation decode and pointer update
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      heads_nxt[i]  = heads_r[i];
      tails_nxt[i]  = tails_r[i];
      counts_nxt[i] = counts_r[i];
    end
    total_nxt  = total_r;
    strobe_nxt = accept;
    status_nxt = status_r;
    served_nxt = 1'b0;
    urg_nxt    = '0;
    store_req  = '0;
    if (accept) begin
      if (in_func == FUNC_ENQ) begin
        if (total_r >= CNT_W'(QUEUE_DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt         = ST_ENQUEUED;
          store_req.wr_en    = 1'b1;
          store_req.wr_addr  = ADDR_W'(enq_idx) * ADDR_W'(QUEUE_DEPTH)
                               + ADDR_W'(tails_r[enq_idx]);
          store_req.wr_data  = in_entry_id;
          tails_nxt[enq_idx] = (tails_r[enq_idx] == PTR_W'(QUEUE_DEPTH - 1)) ?
                               '0 : tails_r[enq_idx] + PTR_W'(1);
          counts_nxt[enq_idx] = counts_r[enq_idx] + CNT_W'(1);
          total_nxt          = total_r + CNT_W'(1);
        end
      end else begin
        if (!any_held) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt         = ST_SERVED;
          served_nxt         = 1'b1;
          urg_nxt            = URG_W'(srv_idx) + URG_W'(1);
          store_req.rd_en    = 1'b1;
          store_req.rd_addr  = ADDR_W'(srv_idx) * ADDR_W'(QUEUE_DEPTH)
                               + ADDR_W'(heads_r[srv_idx]);
          heads_nxt[srv_idx] = (heads_r[srv_idx] == PTR_W'(QUEUE_DEPTH - 1)) ?
                               '0 : heads_r[srv_idx] + PTR_W'(1);
          counts_nxt[srv_idx] = counts_r[srv_idx] - CNT_W'(1);
          total_nxt          = total_r - CNT_W'(1);
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        heads_r[i]  <= '0;
        tails_r[i]  <= '0;
        counts_r[i] <= '0;
      end
      total_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        heads_r[i]  <= heads_nxt[i];
        tails_r[i]  <= tails_nxt[i];
        counts_r[i] <= counts_nxt[i];
      end
      total_r  <= total_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      served_r <= served_nxt;
      urg_r    <= urg_nxt;
      occ_r    <= total_nxt;
    end
  end

  // entry store
  spfq_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (store_rd_data)
  );

  // result transfer
  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_served_id      = served_r ? store_rd_data : '0;
  assign out_served_urgency = urg_r;
  assign out_occupancy      = OCC_W'(occ_r);

endmodule

@@ test/tb.sv @@
// tb: self-checking bench for strict_priority_fifo_queue, level order and fifo order per level
// needs spfq_pkg and the queue rtl; carries its own model of the five-level queue
module tb
  import spfq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // one expected or observed result transfer
  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    served_id;
    logic [URG_W-1:0]   served_urgency;
    logic [OCC_W-1:0]   occupancy;
  } queue_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             in_func = FUNC_ENQ;
  logic [ID_W-1:0]  in_entry_id = '0;
  logic [URG_W-1:0] in_urgency = '0;
  logic             out_strobe;
  logic [ST_W-1:0]  out_status;
  logic [ID_W-1:0]  out_served_id;
  logic [URG_W-1:0] out_served_urgency;
  logic [OCC_W-1:0] out_occupancy;

  strict_priority_fifo_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_entry_id       (in_entry_id),
    .in_urgency        (in_urgency),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_served_id     (out_served_id),
    .out_served_urgency(out_served_urgency),
    .out_occupancy     (out_occupancy)
  );

  always #2 clk = ~clk;

  // model of the queue: one ring of QUEUE_DEPTH slots per level
  logic [ID_W-1:0] level_ring [LEVELS][QUEUE_DEPTH];
  int              ring_head [LEVELS];
  int              ring_tail [LEVELS];
  int              ring_count [LEVELS];
  int              held_total;

  queue_result_t   pending_results [$];
  int              fails;
  int              n_enqueued, n_served, n_empty, n_full;
  bit              no_idle;

  // work out the result of one accepted transfer and update the model
  function automatic queue_result_t predict_transfer(logic op, logic [ID_W-1:0] id,
                                                     logic [URG_W-1:0] urg);
    queue_result_t r;
    int            lvl;
    bit            found;
    r.status         = ST_EMPTY;
    r.served_id      = '0;
    r.served_urgency = '0;
    found            = 1'b0;
    if (op == FUNC_ENQ) begin
      if (held_total >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // out-of-range urgency saturates to the nearest level
        lvl = (urg < 1) ? 1 : ((urg > LEVELS) ? LEVELS : int'(urg));
        level_ring[lvl-1][ring_tail[lvl-1]] = id;
        ring_tail[lvl-1]  = (ring_tail[lvl-1] + 1) % QUEUE_DEPTH;
        ring_count[lvl-1] = ring_count[lvl-1] + 1;
        held_total        = held_total + 1;
        r.status          = ST_ENQUEUED;
      end
    end else begin
      // oldest entry of the most urgent non-empty level
      for (int i = 0; i < LEVELS; i++) begin
        if (!found && ring_count[i] != 0) begin
          found            = 1'b1;
          r.status         = ST_SERVED;
          r.served_id      = level_ring[i][ring_head[i]];
          r.served_urgency = URG_W'(i + 1);
          ring_head[i]     = (ring_head[i] + 1) % QUEUE_DEPTH;
          ring_count[i]    = ring_count[i] - 1;
          held_total       = held_total - 1;
        end
      end
    end
    r.occupancy = OCC_W'(held_total);
    return r;
  endfunction

  // check results against the oldest prediction, then record new transfers
  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_n) begin
      if (out_strobe) begin
        case (out_status)
          ST_ENQUEUED: n_enqueued++;
          ST_SERVED:   n_served++;
          ST_EMPTY:    n_empty++;
          default:     n_full++;
        endcase
        if (pending_results.size() == 0) begin
          fails++;
          $display("%0t: result with nothing pending, status %0d id %0h", $time,
                   out_status, out_served_id);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            fails++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          end
          if (out_served_id !== want.served_id) begin
            fails++;
            $display("%0t: served_id expected %0h actual %0h", $time, want.served_id,
                     out_served_id);
          end
          if (out_served_urgency !== want.served_urgency) begin
            fails++;
            $display("%0t: served_urgency expected %0d actual %0d", $time,
                     want.served_urgency, out_served_urgency);
          end
          if (out_occupancy !== want.occupancy) begin
            fails++;
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                     out_occupancy);
          end
        end
      end
      if (start && !busy)
        pending_results.push_back(predict_transfer(in_func, in_entry_id, in_urgency));
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one item, wait for its transfer, then idle for a while
  task automatic send_item(input logic op, input logic [ID_W-1:0] id,
                           input logic [URG_W-1:0] urg);
    int gap;
    @(negedge clk);
    start       = 1'b1;
    in_func     = op;
    in_entry_id = id;
    in_urgency  = urg;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start       = 1'b0;
      in_func     = 1'($urandom);
      in_entry_id = ID_W'($urandom);
      in_urgency  = URG_W'($urandom);
      repeat (gap - 1)
        @(negedge clk);
    end
  endtask

  // random item with the given share of serves in percent
  task automatic send_random(input int serve_pct);
    send_item(($urandom_range(0, 99) < serve_pct) ? FUNC_SERVE : FUNC_ENQ,
              ID_W'($urandom), URG_W'($urandom_range(0, 7)));
  endtask

  // serving an empty queue, with and without junk on the other fields
  task automatic test_empty_serve();
    send_item(FUNC_SERVE, '0, '0);
    send_item(FUNC_SERVE, '1, '1);
  endtask

  // every urgency code including the saturating ones, extreme ids, then drain
  task automatic test_levels_and_clamp();
    send_item(FUNC_ENQ, 16'hFFFF, 3'd7);
    send_item(FUNC_ENQ, 16'h0000, 3'd6);
    send_item(FUNC_ENQ, 16'h5555, 3'd5);
    send_item(FUNC_ENQ, 16'hAAAA, 3'd4);
    send_item(FUNC_ENQ, 16'h0001, 3'd3);
    send_item(FUNC_ENQ, 16'h8000, 3'd2);
    send_item(FUNC_ENQ, 16'h1234, 3'd1);
    send_item(FUNC_ENQ, 16'hFEDC, 3'd0);
    repeat (9)
      send_item(FUNC_SERVE, ID_W'($urandom), URG_W'($urandom));
  endtask

  // one level filled past its ring end, refused when full, then emptied
  task automatic test_single_level_wrap();
    no_idle = 1'b1;
    repeat (40)
      send_item(FUNC_ENQ, ID_W'($urandom), 3'd2);
    no_idle = 1'b0;
    repeat (30)
      send_item(FUNC_SERVE, ID_W'($urandom), URG_W'($urandom));
    repeat (54)
      send_item(FUNC_ENQ, ID_W'($urandom), 3'd2);
    send_item(FUNC_ENQ, 16'hFFFF, 3'd2);
    send_item(FUNC_ENQ, ID_W'($urandom), 3'd1);
    repeat (65)
      send_item(FUNC_SERVE, ID_W'($urandom), URG_W'($urandom));
  endtask

  // even mix of enqueues and serves, first part back to back
  task automatic test_random_mix();
    no_idle = 1'b1;
    repeat (40)
      send_random(50);
    no_idle = 1'b0;
    repeat (80)
      send_random(50);
  endtask

  // enqueue-heavy run into the full limit, then serve-heavy run to empty
  task automatic test_fill_drain();
    repeat (70)
      send_random(20);
    repeat (70)
      send_random(80);
  endtask

  initial begin : run
    int waited;
    fails      = 0;
    n_enqueued = 0;
    n_served   = 0;
    n_empty    = 0;
    n_full     = 0;
    no_idle    = 1'b0;
    held_total = 0;
    for (int i = 0; i < LEVELS; i++) begin
      ring_head[i]  = 0;
      ring_tail[i]  = 0;
      ring_count[i] = 0;
    end

    repeat (8)
      @(negedge clk);
    rst_n = 1'b1;

    test_empty_serve();
    test_levels_and_clamp();
    test_single_level_wrap();
    test_random_mix();
    test_fill_drain();

    @(negedge clk);
    start = 1'b0;

    // drain the outstanding results, then allow for the registered result
    waited = 0;
    while (pending_results.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (4)
      @(posedge clk);
    if (pending_results.size() != 0) begin
      fails++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end

    $display("covered: %0d enqueued, %0d served, %0d refused as full, %0d empty serves",
             n_enqueued, n_served, n_full, n_empty);
    $display("mismatches: %0d", fails);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #1ms;
    $display("timeout at %0t", $time);
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/spfq_pkg.sv
rtl/spfq_store.sv
rtl/strict_priority_fifo_queue.sv
test/tb.sv
